// File: hdl/futex_wait_queue_table_macros.svh
`ifndef FUTEX_WAIT_QUEUE_TABLE_MACROS_SVH
`define FUTEX_WAIT_QUEUE_TABLE_MACROS_SVH

// same-cycle property
`define FWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication
`define FWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fwq_pkg.sv
`timescale 1ns / 1ps
package fwq_pkg;

  localparam int BUCKETS    = 64;
  localparam int WAITERS    = 64;
  localparam int RESULT_CAP = 64;
  localparam int BB         = $clog2(BUCKETS);
  localparam int SW         = $clog2(WAITERS);
  localparam int PW         = $clog2(WAITERS + 1);
  localparam logic [PW-1:0] NIL = PW'(WAITERS);
  localparam logic [6:0] CAP7 = 7'(RESULT_CAP);

  typedef enum logic [2:0] {
    OP_ENQ       = 3'd0,
    OP_COUNT     = 3'd1,
    OP_WAKE      = 3'd2,
    OP_WAKE_MASK = 3'd3,
    OP_REQUEUE   = 3'd4,
    OP_REMOVE    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    HS_SRC = 2'd0,
    HS_KEY = 2'd1,
    HS_DST = 2'd2
  } hsel_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] space_key;
    logic [47:0] addr_key;
    logic [5:0]  waiter_id;
    logic [31:0] wake_bits;
    logic [47:0] dest_space;
    logic [47:0] dest_addr;
    logic [6:0]  wake_limit;
    logic [6:0]  move_limit;
  } in_t;

  typedef struct packed {
    logic [5:0] slot_out;
    logic       slot_valid;
    logic       action;
    logic [6:0] total;
    logic       status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [47:0] space;
    logic [47:0] addr;
    logic [31:0] mask;
  } key_t;

  typedef struct packed {
    logic  load;
    logic  enq;
    logic  key_rd;
    logic  brd;
    hsel_e hsel;
    logic  bld;
    logic  node_rd;
    logic  wev;
    logic  mstart;
    logic  mev;
    logic  map1;
    logic  app;
    logic  fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       wid_ok;
    logic       queued;
    logic       wlim_zero;
    logic       cur_nil;
    logic       hit;
    logic       wake_done;
    logic       can_emit;
    logic       out_free;
    logic       move_ok;
    logic       move_done;
    logic       at_end;
    logic       pend_v;
  } sts_t;

  function automatic logic [BB-1:0] bucket_of(input logic [47:0] s, input logic [47:0] a);
    return s[4 +: BB] ^ a[4 +: BB] ^ s[12 +: BB] ^ a[16 +: BB];
  endfunction

endpackage

// File: hdl/fwq_if.sv
`timescale 1ns / 1ps
interface fwq_in_if import fwq_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fwq_out_if import fwq_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fwq_ram.sv
`timescale 1ns / 1ps
module fwq_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic                                re_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                        rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: hdl/fwq_ctrl.sv
`timescale 1ns / 1ps
module fwq_ctrl import fwq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_DISP = 14'b00000000000010,
    ST_ENQ  = 14'b00000000000100,
    ST_RKEY = 14'b00000000001000,
    ST_BRD  = 14'b00000000010000,
    ST_BLD  = 14'b00000000100000,
    ST_WRD  = 14'b00000001000000,
    ST_WEV  = 14'b00000010000000,
    ST_WEND = 14'b00000100000000,
    ST_MRD  = 14'b00001000000000,
    ST_MEV  = 14'b00010000000000,
    ST_MAP1 = 14'b00100000000000,
    ST_APP  = 14'b01000000000000,
    ST_FIN  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   is_wake;

  assign is_wake = (sts_i.op == OP_WAKE) || (sts_i.op == OP_WAKE_MASK) ||
                   (sts_i.op == OP_REQUEUE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (sts_i.op == OP_ENQ) begin
          state_d = ST_ENQ;
        end else if (sts_i.op == OP_COUNT || is_wake) begin
          state_d = ST_BRD;
        end else if (sts_i.op == OP_REMOVE && sts_i.wid_ok && sts_i.queued) begin
          state_d = ST_RKEY;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_ENQ: begin
        cmd_o.enq  = 1'b1;
        cmd_o.brd  = 1'b1;
        cmd_o.hsel = HS_SRC;
        state_d    = (sts_i.wid_ok && !sts_i.queued) ? ST_APP : ST_FIN;
      end
      ST_RKEY: begin
        cmd_o.key_rd = 1'b1;
        state_d      = ST_BRD;
      end
      ST_BRD: begin
        cmd_o.brd  = 1'b1;
        cmd_o.hsel = (sts_i.op == OP_REMOVE) ? HS_KEY : HS_SRC;
        state_d    = ST_BLD;
      end
      ST_BLD: begin
        cmd_o.bld = 1'b1;
        state_d   = (is_wake && sts_i.wlim_zero) ? ST_WEND : ST_WRD;
      end
      ST_WRD: begin
        if (sts_i.cur_nil) begin
          state_d = is_wake ? ST_WEND : ST_FIN;
        end else begin
          cmd_o.node_rd = 1'b1;
          state_d       = ST_WEV;
        end
      end
      ST_WEV: begin
        if (!(sts_i.hit && is_wake && !sts_i.can_emit)) begin
          cmd_o.wev = 1'b1;
          priority if (sts_i.hit && sts_i.op == OP_REMOVE) begin
            state_d = ST_FIN;
          end else if (sts_i.hit && is_wake && sts_i.wake_done) begin
            state_d = ST_WEND;
          end else begin
            state_d = ST_WRD;
          end
        end
      end
      ST_WEND: begin
        if (sts_i.move_ok) begin
          cmd_o.mstart = 1'b1;
          state_d      = ST_MRD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MRD: begin
        if (sts_i.cur_nil) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.node_rd = 1'b1;
          state_d       = ST_MEV;
        end
      end
      ST_MEV: begin
        if (!(sts_i.hit && !sts_i.can_emit)) begin
          cmd_o.mev = 1'b1;
          priority if (sts_i.hit) begin
            state_d = ST_MAP1;
          end else if (sts_i.at_end) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_MRD;
          end
        end
      end
      ST_MAP1: begin
        cmd_o.map1 = 1'b1;
        cmd_o.hsel = HS_DST;
        state_d    = ST_APP;
      end
      ST_APP: begin
        cmd_o.app = 1'b1;
        state_d   = (sts_i.op == OP_ENQ || sts_i.move_done) ? ST_FIN : ST_MRD;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: hdl/fwq_dp.sv
`timescale 1ns / 1ps
module fwq_dp import fwq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  in_t  in_data_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output out_t out_data_o
);
  in_t            req_q;
  logic [PW-1:0]  head_q, tail_q, cur_q, prev_q, end_q, nx_q, app_q;
  logic [BB-1:0]  bkt_q, bkt_rd_q;
  logic           bvr_q, atend_q, status_q;
  logic [6:0]     cnt_q, total_q;
  logic           bv_q [BUCKETS];
  logic           queued_q [WAITERS];
  out_t           pend_q, out_q, res_new, fin_res;
  logic           pend_v_q, out_v_q;

  logic [SW-1:0]  wid_idx, cur_idx;
  logic           wid_ok, is_wake, keymatch, mask_ok, hit, do_unlink, enq_do, emit;
  logic [PW-1:0]  nx_rd, bk_head, bk_tail, ul_head, ul_tail, ap_head;
  logic [2*PW-1:0] bk_rd;
  key_t           kd;

  logic            nxt_we, key_we, key_re, bkt_we, bkt_re;
  logic [SW-1:0]   nxt_waddr, key_waddr, key_raddr;
  logic [PW-1:0]   nxt_wdata;
  key_t            key_wdata;
  logic [BB-1:0]   bkt_waddr, bkt_raddr;
  logic [2*PW-1:0] bkt_wdata;

  assign wid_idx  = SW'(req_q.waiter_id);
  assign cur_idx  = cur_q[SW-1:0];
  assign wid_ok   = 32'(req_q.waiter_id) < 32'(WAITERS);
  assign is_wake  = (req_q.op == OP_WAKE) || (req_q.op == OP_WAKE_MASK) ||
                    (req_q.op == OP_REQUEUE);
  assign keymatch = (kd.space == req_q.space_key) && (kd.addr == req_q.addr_key);
  assign mask_ok  = (kd.mask & req_q.wake_bits) != '0;

  always_comb begin
    priority if (req_q.op == OP_REMOVE) begin
      hit = (cur_q == PW'(req_q.waiter_id));
    end else if (req_q.op == OP_WAKE_MASK) begin
      hit = keymatch && mask_ok;
    end else begin
      hit = keymatch;
    end
  end

  assign do_unlink = (cmd_i.wev || cmd_i.mev) && hit && (req_q.op != OP_COUNT);
  assign enq_do    = cmd_i.enq && wid_ok && !queued_q[wid_idx];
  assign emit      = (cmd_i.wev && do_unlink && is_wake) || (cmd_i.mev && hit);

  assign bk_head = bvr_q ? bk_rd[2*PW-1:PW] : NIL;
  assign bk_tail = bvr_q ? bk_rd[PW-1:0] : NIL;
  assign ul_head = (prev_q == NIL) ? nx_rd : head_q;
  assign ul_tail = (tail_q == cur_q) ? prev_q : tail_q;
  assign ap_head = (bk_head == NIL) ? app_q : bk_head;

  // next pointer memory writes
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = wid_idx;
    nxt_wdata = NIL;
    priority if (enq_do) begin
      nxt_we = 1'b1;
    end else if (do_unlink && prev_q != NIL) begin
      nxt_we    = 1'b1;
      nxt_waddr = prev_q[SW-1:0];
      nxt_wdata = nx_rd;
    end else if (cmd_i.map1) begin
      nxt_we    = 1'b1;
      nxt_waddr = app_q[SW-1:0];
    end else if (cmd_i.app && bk_head != NIL) begin
      nxt_we    = 1'b1;
      nxt_waddr = bk_tail[SW-1:0];
      nxt_wdata = app_q;
    end else begin
      nxt_we = 1'b0;
    end
  end

  // key memory
  always_comb begin
    key_we    = enq_do || (cmd_i.mev && hit);
    key_waddr = enq_do ? wid_idx : cur_idx;
    key_wdata = enq_do ? key_t'{req_q.space_key, req_q.addr_key, req_q.wake_bits}
                       : key_t'{req_q.dest_space, req_q.dest_addr, kd.mask};
    key_re    = cmd_i.node_rd || cmd_i.key_rd;
    key_raddr = cmd_i.key_rd ? wid_idx : cur_idx;
  end

  // bucket head and tail memory
  always_comb begin
    bkt_we    = do_unlink || cmd_i.app;
    bkt_waddr = cmd_i.app ? bkt_rd_q : bkt_q;
    bkt_wdata = cmd_i.app ? {ap_head, app_q} : {ul_head, ul_tail};
    bkt_re    = cmd_i.brd || cmd_i.map1;
    unique case (cmd_i.hsel)
      HS_KEY:  bkt_raddr = bucket_of(kd.space, kd.addr);
      HS_DST:  bkt_raddr = bucket_of(req_q.dest_space, req_q.dest_addr);
      default: bkt_raddr = bucket_of(req_q.space_key, req_q.addr_key);
    endcase
  end

  fwq_ram #(.W(PW), .D(WAITERS)) u_next (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (cmd_i.node_rd),
    .raddr_i (cur_idx),
    .rdata_o (nx_rd)
  );

  fwq_ram #(.W($bits(key_t)), .D(WAITERS)) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (kd)
  );

  fwq_ram #(.W(2 * PW), .D(BUCKETS)) u_bucket (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) begin
        bv_q[i] <= 1'b0;
      end
      for (int i = 0; i < WAITERS; i++) begin
        queued_q[i] <= 1'b0;
      end
    end else begin
      if (bkt_we) begin
        bv_q[bkt_waddr] <= 1'b1;
      end
      if (enq_do) begin
        queued_q[wid_idx] <= 1'b1;
      end else if (cmd_i.wev && do_unlink) begin
        queued_q[cur_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bkt_re) begin
      bvr_q    <= bv_q[bkt_raddr];
      bkt_rd_q <= bkt_raddr;
    end
    if (cmd_i.load) begin
      req_q    <= in_data_i;
      cnt_q    <= '0;
      total_q  <= '0;
      status_q <= 1'b0;
    end
    if (cmd_i.enq) begin
      app_q <= PW'(req_q.waiter_id);
      if (!enq_do) begin
        status_q <= wid_ok && queued_q[wid_idx];
      end
    end
    if (cmd_i.bld) begin
      head_q <= bk_head;
      tail_q <= bk_tail;
      bkt_q  <= bkt_rd_q;
      cur_q  <= bk_head;
      prev_q <= NIL;
      cnt_q  <= '0;
    end
    if (cmd_i.wev) begin
      cur_q <= nx_rd;
      if (do_unlink) begin
        head_q <= ul_head;
        tail_q <= ul_tail;
        if (is_wake) begin
          cnt_q   <= cnt_q + 7'd1;
          total_q <= total_q + 7'd1;
        end
      end else begin
        prev_q <= cur_q;
        if (hit && req_q.op == OP_COUNT) begin
          total_q <= total_q + 7'd1;
        end
      end
    end
    if (cmd_i.mstart) begin
      end_q  <= tail_q;
      cur_q  <= head_q;
      prev_q <= NIL;
      cnt_q  <= '0;
    end
    if (cmd_i.mev) begin
      atend_q <= (cur_q == end_q);
      if (hit) begin
        head_q  <= ul_head;
        tail_q  <= ul_tail;
        app_q   <= cur_q;
        nx_q    <= nx_rd;
        cnt_q   <= cnt_q + 7'd1;
        total_q <= total_q + 7'd1;
      end else begin
        prev_q <= cur_q;
        cur_q  <= nx_rd;
      end
    end
    if (cmd_i.app) begin
      cur_q <= nx_q;
      if (bkt_rd_q == bkt_q) begin
        head_q <= ap_head;
        tail_q <= app_q;
      end
    end
  end

  always_comb begin
    res_new            = '0;
    res_new.slot_out   = 6'(cur_q);
    res_new.slot_valid = 1'b1;
    res_new.action     = cmd_i.mev;
    res_new.total      = total_q + 7'd1;
    fin_res            = '0;
    if (pend_v_q) begin
      fin_res = pend_q;
    end else begin
      fin_res.total  = total_q;
      fin_res.status = status_q;
    end
    fin_res.last = 1'b1;
  end

  // one result held back so the final beat can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      pend_q   <= '0;
      out_q    <= '0;
    end else begin
      priority if (cmd_i.fin) begin
        out_q    <= fin_res;
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (emit) begin
        if (pend_v_q) begin
          out_q   <= pend_q;
          out_v_q <= 1'b1;
        end else if (out_v_q && out_ready_i) begin
          out_v_q <= 1'b0;
        end
        pend_q   <= res_new;
        pend_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o           = '0;
    sts_o.op        = req_q.op;
    sts_o.wid_ok    = wid_ok;
    sts_o.queued    = queued_q[wid_idx];
    sts_o.wlim_zero = (req_q.wake_limit == '0);
    sts_o.cur_nil   = (cur_q == NIL);
    sts_o.hit       = hit;
    sts_o.wake_done = ((cnt_q + 7'd1) == req_q.wake_limit) || ((total_q + 7'd1) == CAP7);
    sts_o.out_free  = !out_v_q || out_ready_i;
    sts_o.can_emit  = !pend_v_q || !out_v_q || out_ready_i;
    sts_o.move_ok   = (req_q.op == OP_REQUEUE) && (req_q.move_limit != '0) &&
                      (total_q != CAP7) && (tail_q != NIL);
    sts_o.move_done = atend_q || (cnt_q == req_q.move_limit) || (total_q == CAP7);
    sts_o.at_end    = (cur_q == end_q);
    sts_o.pend_v    = pend_v_q;
  end
endmodule

// File: hdl/futex_wait_queue_table.sv
`timescale 1ns / 1ps
// Hashed futex wait table: 64 waiter slots in per-bucket FIFO lists over 64 buckets.
// One operation at a time; a new beat is taken only once the previous operation
// has handed its final result to the output register. Count, remove and wake walk
// the source bucket list node by node. A requeue walks the source bucket a second
// time and appends each moved waiter at the destination tail; every walk goes
// through the single read port of the next-pointer, key and bucket memories.
// A result beat that finds the output busy stalls the walk. Each result beat leaves
// one beat behind its discovery so the final beat carries last.
`include "futex_wait_queue_table_macros.svh"
module futex_wait_queue_table import fwq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwq_in_if.sink     in_i,
  fwq_out_if.source  out_o
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  fwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fwq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  `FWQ_ASSERT(a_idle_drained, in_ready |-> !sts.pend_v, "held result left at idle")
  `FWQ_ASSERT(a_fin_free, cmd.fin |-> sts.out_free, "final beat overwrote output")
  `FWQ_ASSERT_NEXT(a_one_op, in_i.valid && in_ready, !in_ready, "second beat while busy")
endmodule
